// File: hdl/assert_macros.svh
// Assertion helpers shared by the ramp generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that an expression holds at every clock edge out of reset
`define STRAMP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("stramp: assertion failed");
// Check that the consequent holds in the cycle after the antecedent
`define STRAMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stramp: assertion failed");
`else
`define STRAMP_ASSERT(lbl, clk, rst_n, prop)
`define STRAMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/stramp_pkg.sv
package stramp_pkg;

    localparam int PERIOD_W = 16;
    localparam int STEPS_W  = 31;
    localparam int PWIDTH_W = 15;
    localparam int REQ_W    = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = {PERIOD_W{1'b1}};
    localparam logic [STEPS_W-1:0]  STEPS_MAX    = {STEPS_W{1'b1}};

    // Command codes of an input beat
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RAMP  = 2'd1;
    localparam logic [1:0] MODE_CONST = 2'd2;

    // Ramp phase codes as reported on the result channel
    localparam logic [1:0] RPH_NONE   = 2'd0;
    localparam logic [1:0] RPH_ACCEL  = 2'd1;
    localparam logic [1:0] RPH_CRUISE = 2'd2;
    localparam logic [1:0] RPH_DECEL  = 2'd3;

    typedef enum logic [3:0] {
        PH_NONE   = 4'b0001,
        PH_ACCEL  = 4'b0010,
        PH_CRUISE = 4'b0100,
        PH_DECEL  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic signed [REQ_W-1:0] step_request;
        logic [PERIOD_W-1:0] period_request;
        logic [PERIOD_W-1:0] ramp_increment;
    } item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] step_period;
        logic [PWIDTH_W-1:0] pulse_width;
        logic                pulse_running;
        logic                direction;
        logic [1:0]          ramp_phase;
        logic [STEPS_W-1:0]  steps_left;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_ACCEL:  code = RPH_ACCEL;
            PH_CRUISE: code = RPH_CRUISE;
            PH_DECEL:  code = RPH_DECEL;
            default:   code = RPH_NONE;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/stramp_if.sv
interface stramp_item_if
    import stramp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic signed [REQ_W-1:0] step_request;
    logic [PERIOD_W-1:0]     period_request;
    logic [PERIOD_W-1:0]     ramp_increment;

    modport source (output valid, mode, step_request, period_request, ramp_increment,
                    input ready);
    modport sink (input valid, mode, step_request, period_request, ramp_increment,
                  output ready);
endinterface

interface stramp_result_if
    import stramp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] step_period;
    logic [PWIDTH_W-1:0] pulse_width;
    logic                pulse_running;
    logic                direction;
    logic [1:0]          ramp_phase;
    logic [STEPS_W-1:0]  steps_left;

    modport source (output valid, step_period, pulse_width, pulse_running, direction,
                    ramp_phase, steps_left, input ready);
    modport sink (input valid, step_period, pulse_width, pulse_running, direction,
                  ramp_phase, steps_left, output ready);
endinterface

interface stramp_cfg_if
    import stramp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: hdl/stramp_in_stage.sv
module stramp_in_stage
    import stramp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    stramp_item_if.sink       item_in,
    input  logic              drain_ok,
    output logic              hold_valid,
    output item_t             hold_item
);

    logic  valid_reg;
    item_t item_reg;

    // Take a new beat when empty or when the held one moves on this cycle
    assign item_in.ready = !valid_reg || drain_ok;
    assign hold_valid    = valid_reg;
    assign hold_item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_in.valid && item_in.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (drain_ok)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            item_reg.mode           <= item_in.mode;
            item_reg.step_request   <= item_in.step_request;
            item_reg.period_request <= item_in.period_request;
            item_reg.ramp_increment <= item_in.ramp_increment;
        end
    end

endmodule

// File: hdl/stramp_ramp_state.sv
module stramp_ramp_state
    import stramp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    stramp_cfg_if.sink        cfg,
    input  logic              fire,
    input  item_t             item,
    output result_t           result_next
);

    logic [PERIOD_W-1:0] start_period_reg;
    phase_t              phase_reg, phase_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] goal_reg, goal_next;
    logic [PERIOD_W-1:0] inc_reg, inc_next;
    logic [STEPS_W-1:0]  accel_reg, accel_next;
    logic [STEPS_W-1:0]  remaining_reg, remaining_next;
    logic                running_reg, running_next;
    logic                dir_reg, dir_next;

    logic                req_neg;
    logic [REQ_W-1:0]    req_mag;
    logic [STEPS_W-1:0]  load_steps;
    logic [PERIOD_W:0]   period_sum;

    assign cfg.ready = 1'b1;

    // Magnitude of the signed step request, clamped to 31 bits
    assign req_neg    = item.step_request[REQ_W-1];
    assign req_mag    = req_neg ? (~item.step_request + 1'b1) : item.step_request;
    assign load_steps = req_mag[REQ_W-1] ? STEPS_MAX : req_mag[STEPS_W-1:0];

    // Lengthened period for deceleration, carry flags saturation
    assign period_sum = {1'b0, period_reg} + {1'b0, inc_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        period_next    = period_reg;
        goal_next      = goal_reg;
        inc_next       = inc_reg;
        accel_next     = accel_reg;
        remaining_next = remaining_reg;
        running_next   = running_reg;
        dir_next       = dir_reg;
        case (item.mode)
            MODE_TICK:
            begin
                case (phase_reg)
                    PH_ACCEL:
                    begin
                        if (period_reg >= goal_reg)
                        begin
                            period_next = (period_reg > inc_reg) ? (period_reg - inc_reg)
                                                                 : '0;
                            if (accel_reg != STEPS_MAX)
                            begin
                                accel_next = accel_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_CRUISE;
                        end
                    end
                    PH_CRUISE:
                    begin
                        if (remaining_reg <= accel_reg)
                        begin
                            phase_next = PH_DECEL;
                        end
                    end
                    PH_DECEL:
                    begin
                        if (accel_reg != '0)
                        begin
                            period_next = period_sum[PERIOD_W] ? PERIOD_MAX
                                                               : period_sum[PERIOD_W-1:0];
                            accel_next  = accel_reg - 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_NONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                // Count down the move; stop pulses on the last step
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - 1'b1;
                    if (remaining_reg == {{(STEPS_W-1){1'b0}}, 1'b1})
                    begin
                        running_next = 1'b0;
                    end
                end
            end
            MODE_RAMP:
            begin
                remaining_next = load_steps;
                running_next   = (load_steps != '0);
                dir_next       = !req_neg;
                phase_next     = PH_ACCEL;
                inc_next       = item.ramp_increment;
                goal_next      = item.period_request;
                period_next    = start_period_reg;
                accel_next     = '0;
            end
            MODE_CONST:
            begin
                remaining_next = load_steps;
                running_next   = (load_steps != '0);
                dir_next       = !req_neg;
                phase_next     = PH_NONE;
                period_next    = item.period_request;
            end
            default:
            begin
            end
        endcase
    end

    // Report the state after the update
    always_comb
    begin
        result_next.step_period   = period_next;
        result_next.pulse_width   = period_next[PERIOD_W-1:1];
        result_next.pulse_running = running_next;
        result_next.direction     = dir_next;
        result_next.ramp_phase    = phase_code(phase_next);
        result_next.steps_left    = remaining_next;
    end

    // Hold the start period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_period_reg <= PERIOD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            start_period_reg <= cfg.data;
        end
    end

    // Advance the move state once per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NONE;
            period_reg    <= PERIOD_RESET;
            goal_reg      <= '0;
            inc_reg       <= '0;
            accel_reg     <= '0;
            remaining_reg <= '0;
            running_reg   <= 1'b0;
            dir_reg       <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            period_reg    <= period_next;
            goal_reg      <= goal_next;
            inc_reg       <= inc_next;
            accel_reg     <= accel_next;
            remaining_reg <= remaining_next;
            running_reg   <= running_next;
            dir_reg       <= dir_next;
        end
    end

endmodule

// File: hdl/stramp_out_stage.sv
module stramp_out_stage
    import stramp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  result_t           result_next,
    stramp_result_if.source   result_out,
    output logic              out_free
);

    logic    valid_reg;
    result_t data_reg;

    // Free when empty or when the held beat is taken this cycle
    assign out_free = !valid_reg || result_out.ready;

    assign result_out.valid         = valid_reg;
    assign result_out.step_period   = data_reg.step_period;
    assign result_out.pulse_width   = data_reg.pulse_width;
    assign result_out.pulse_running = data_reg.pulse_running;
    assign result_out.direction     = data_reg.direction;
    assign result_out.ramp_phase    = data_reg.ramp_phase;
    assign result_out.steps_left    = data_reg.steps_left;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= result_next;
        end
    end

endmodule

// File: hdl/stepper_trapezoid_ramp_core.sv
// Trapezoidal step-period generator for a stepper motor.
// Channels:
//   cfg        - write beats load start_period (always ready).
//   item_in    - command beats: step tick, ramped start or constant start.
//   result_out - one beat per command: period, pulse width, running flag,
//                direction, ramp phase and remaining steps after the update.
// Path: a command accepted on item_in loads the input register; when the
// result register has room, the state update is written into the result
// register, which holds the beat until result_out takes it.
// Throughput: one command per clock while result_out is ready; the state update
// is a single add or compare path between the input and result registers.
// Stall: when result_out is held off, the result register keeps its beat and
// the input register takes one more command; ready then drops until the
// result is taken. No beat is lost or repeated.
// Reset: period 1000, start_period 1000, direction forward, no move, both
// registers empty. Write cfg only while no command is in flight.
`include "assert_macros.svh"

module stepper_trapezoid_ramp_core
    import stramp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    stramp_cfg_if.sink        cfg,
    stramp_item_if.sink       item_in,
    stramp_result_if.source   result_out
);

    logic    hold_valid;
    item_t   hold_item;
    logic    out_free;
    logic    fire;
    result_t result_next;
    logic    in_beat;
    logic    run_ok;

    // Move the held command into the result register when there is room
    assign fire = hold_valid && out_free;

    stramp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .drain_ok   (out_free),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    stramp_ramp_state u_ramp_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (fire),
        .item        (hold_item),
        .result_next (result_next)
    );

    stramp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .result_next (result_next),
        .result_out  (result_out),
        .out_free    (out_free)
    );

    // Terms for the checks below
    assign in_beat = item_in.valid && item_in.ready;
    assign run_ok  = result_out.pulse_running == (result_out.steps_left != '0);

    `STRAMP_ASSERT_NEXT(a_accept_fills_hold, clk, rst_n, in_beat, hold_valid)
    `STRAMP_ASSERT_NEXT(a_fire_shows_result, clk, rst_n, fire, result_out.valid)
    `STRAMP_ASSERT(a_full_blocks_input, clk, rst_n, !(hold_valid && !out_free) || !item_in.ready)
    `STRAMP_ASSERT(a_running_matches_steps, clk, rst_n, !result_out.valid || run_ok)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import stramp_pkg::*;

    // Spare command code: the block must leave its state alone
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned MAX_PRINTED = 200;

    logic clk;
    logic rst_n;

    stramp_cfg_if    cfg_if();
    stramp_item_if   item_if();
    stramp_result_if res_if();

    stepper_trapezoid_ramp_core u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .item_in    (item_if),
        .result_out (res_if)
    );

    // Command beats waiting to be sent, start_period writes, expected result beats
    item_t           cmd_backlog[$];
    logic [15:0]     start_period_writes[$];
    result_t         motion_expect[$];

    item_t           next_cmd;
    item_t           on_bus;
    result_t         want_beat;
    int unsigned     gap_left;
    int unsigned     stall_left;
    int unsigned     hold_left;
    int unsigned     next_hold_at;
    int unsigned     holds_done;
    int unsigned     beats_in;
    int unsigned     cmds_queued;
    int unsigned     err_count;
    bit              idle_on;

    // Shadow of the motion state
    logic [15:0]     ramp_start;
    logic [1:0]      mv_phase;
    logic [15:0]     mv_period;
    logic [15:0]     mv_goal;
    logic [15:0]     mv_inc;
    logic [30:0]     mv_accel;
    logic [30:0]     mv_left;
    logic            mv_run;
    logic            mv_fwd;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic flag_error(input string what, input longint unsigned got,
                              input longint unsigned want);
        if (err_count < MAX_PRINTED)
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            flag_error(what, got, want);
    endtask

    // Apply one command to the shadow state and return the beat it should produce
    function automatic result_t predict_motion(input item_t cmd);
        logic [31:0] raw;
        logic [31:0] mag;
        logic [16:0] sum;
        result_t     r;
        case (cmd.mode)
            MODE_TICK:
            begin
                case (mv_phase)
                    RPH_ACCEL:
                    begin
                        if (mv_period >= mv_goal)
                        begin
                            mv_period = (mv_period > mv_inc) ? mv_period - mv_inc : 16'd0;
                            if (mv_accel != STEPS_MAX)
                                mv_accel = mv_accel + 1'b1;
                        end
                        else
                            mv_phase = RPH_CRUISE;
                    end
                    RPH_CRUISE:
                    begin
                        if (mv_left <= mv_accel)
                            mv_phase = RPH_DECEL;
                    end
                    RPH_DECEL:
                    begin
                        if (mv_accel != '0)
                        begin
                            sum = {1'b0, mv_period} + {1'b0, mv_inc};
                            mv_period = sum[16] ? PERIOD_MAX : sum[15:0];
                            mv_accel = mv_accel - 1'b1;
                        end
                        else
                            mv_phase = RPH_NONE;
                    end
                    default: ;
                endcase
                if (mv_left != '0)
                begin
                    mv_left = mv_left - 1'b1;
                    if (mv_left == '0)
                        mv_run = 1'b0;
                end
            end
            MODE_RAMP, MODE_CONST:
            begin
                // Take the magnitude, clamp the most negative count
                raw = cmd.step_request;
                mv_fwd = !raw[31];
                mag = raw[31] ? (~raw + 32'd1) : raw;
                if (mag > {1'b0, STEPS_MAX})
                    mag = {1'b0, STEPS_MAX};
                mv_left = mag[30:0];
                mv_run = (mag != 32'd0);
                if (cmd.mode == MODE_RAMP)
                begin
                    mv_phase = RPH_ACCEL;
                    mv_inc = cmd.ramp_increment;
                    mv_goal = cmd.period_request;
                    mv_period = ramp_start;
                    mv_accel = '0;
                end
                else
                begin
                    mv_phase = RPH_NONE;
                    mv_period = cmd.period_request;
                end
            end
            default: ;
        endcase
        r.step_period = mv_period;
        r.pulse_width = mv_period[15:1];
        r.pulse_running = mv_run;
        r.direction = mv_fwd;
        r.ramp_phase = mv_phase;
        r.steps_left = mv_left;
        return r;
    endfunction

    // Configuration driver: one start_period write per beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_if.valid <= 1'b0;
            cfg_if.data <= '0;
            ramp_start <= PERIOD_RESET;
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
                ramp_start <= cfg_if.data;
            if (!cfg_if.valid || cfg_if.ready)
            begin
                if (start_period_writes.size() != 0)
                begin
                    cfg_if.data <= start_period_writes.pop_front();
                    cfg_if.valid <= 1'b1;
                end
                else
                    cfg_if.valid <= 1'b0;
            end
        end
    end

    // Command driver: predict each accepted beat, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
            item_if.mode <= MODE_TICK;
            item_if.step_request <= '0;
            item_if.period_request <= '0;
            item_if.ramp_increment <= '0;
            on_bus <= '0;
            gap_left <= 0;
            beats_in <= 0;
            mv_phase = RPH_NONE;
            mv_period = PERIOD_RESET;
            mv_goal = '0;
            mv_inc = '0;
            mv_accel = '0;
            mv_left = '0;
            mv_run = 1'b0;
            mv_fwd = 1'b1;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
            begin
                motion_expect.push_back(predict_motion(on_bus));
                beats_in <= beats_in + 1;
            end
            if (!item_if.valid || item_if.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    item_if.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    on_bus <= next_cmd;
                    item_if.mode <= next_cmd.mode;
                    item_if.step_request <= next_cmd.step_request;
                    item_if.period_request <= next_cmd.period_request;
                    item_if.ramp_increment <= next_cmd.ramp_increment;
                    item_if.valid <= 1'b1;
                    gap_left <= idle_on ? pick_gap() : 0;
                end
                else
                    item_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            next_hold_at <= 400;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && beats_in >= next_hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 600;
            holds_done <= holds_done + 1;
        end
    end

    // Result monitor: check each beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (motion_expect.size() == 0)
                    flag_error("result beat with nothing expected", 1, 0);
                else
                begin
                    want_beat = motion_expect.pop_front();
                    check_field("step_period", res_if.step_period, want_beat.step_period);
                    check_field("pulse_width", res_if.pulse_width, want_beat.pulse_width);
                    check_field("pulse_running", res_if.pulse_running,
                                want_beat.pulse_running);
                    check_field("direction", res_if.direction, want_beat.direction);
                    check_field("ramp_phase", res_if.ramp_phase, want_beat.ramp_phase);
                    check_field("steps_left", res_if.steps_left, want_beat.steps_left);
                end
            end
            if (hold_left != 0)
                res_if.ready <= 1'b0;
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                res_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_gap();
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    function automatic void push_cmd(input logic [1:0] mode, input logic signed [31:0] steps,
                                     input logic [15:0] per, input logic [15:0] inc);
        item_t c;
        c.mode = mode;
        c.step_request = steps;
        c.period_request = per;
        c.ramp_increment = inc;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endfunction

    function automatic void push_tick();
        push_cmd(MODE_TICK, $urandom, 16'($urandom), 16'($urandom));
    endfunction

    // Hold the sender until every expected beat has come back
    task automatic wait_for_drain();
        while (cmd_backlog.size() != 0 || item_if.valid || motion_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_start_period(input logic [15:0] value);
        start_period_writes.push_back(value);
        while (start_period_writes.size() != 0 || cfg_if.valid)
            @(posedge clk);
    endtask

    // One move: mostly complete ramps and constant moves, some noise and aborts
    task automatic queue_random_move(input logic [15:0] sp);
        int unsigned        kind;
        int unsigned        len;
        int unsigned        ticks;
        int unsigned        i;
        logic signed [31:0] steps;
        logic [15:0]        goal;
        logic [15:0]        inc;
        kind = $urandom_range(0, 9);
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48);
        steps = len;
        if ($urandom_range(0, 1) == 1)
            steps = -steps;
        goal = 16'($urandom_range(0, sp));
        case ($urandom_range(0, 7))
            0: inc = 16'($urandom);
            1: inc = '0;
            default: inc = 16'($urandom_range(1, sp / 6 + 1));
        endcase
        ticks = 0;
        if (kind <= 5)
        begin
            push_cmd(MODE_RAMP, steps, goal, inc);
            ticks = len + $urandom_range(0, 12);
        end
        else if (kind <= 7)
        begin
            push_cmd(MODE_CONST, steps, 16'($urandom), 16'($urandom));
            ticks = len + $urandom_range(0, 4);
        end
        else if (kind == 8)
        begin
            for (i = $urandom_range(1, 4); i != 0; i--)
                push_cmd(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 16'($urandom));
        end
        else
        begin
            // Abort the move partway; the next start cuts in
            push_cmd(MODE_RAMP, steps, goal, inc);
            ticks = $urandom_range(0, len / 2);
        end
        for (i = 0; i < ticks; i++)
            push_tick();
    endtask

    task automatic run_random_phase(input logic [15:0] sp, input bit idling,
                                    input int unsigned quota);
        int unsigned target;
        idle_on = idling;
        set_start_period(sp);
        target = cmds_queued + quota;
        while (cmds_queued < target)
            queue_random_move(sp);
        wait_for_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmds_queued = 0;
        err_count = 0;
        idle_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short ramp through every phase, sign and saturation cases
        set_start_period(16'd40);
        push_cmd(MODE_SPARE, -5, 16'd123, 16'd77);
        push_cmd(MODE_TICK, 0, 16'd0, 16'd0);
        push_cmd(MODE_RAMP, 8, 16'd20, 16'd7);
        repeat (10) push_tick();
        push_cmd(MODE_CONST, 32'h8000_0000, 16'hFFFF, 16'd0);
        push_tick();
        push_cmd(MODE_CONST, 0, 16'd0, 16'hFFFF);
        push_cmd(MODE_RAMP, -1, 16'd0, 16'hFFFF);
        push_tick();
        wait_for_drain();

        // Directed: shorten to zero, then lengthen past the top of the range
        set_start_period(16'hFFFF);
        push_cmd(MODE_RAMP, 3, 16'd1, 16'd40000);
        repeat (7) push_tick();
        push_cmd(MODE_CONST, 32'h7FFF_FFFF, 16'd1, 16'd0);
        wait_for_drain();

        // Random moves across several start periods
        run_random_phase(PERIOD_RESET, 1'b1, 255);
        run_random_phase(16'd1, 1'b1, 255);
        run_random_phase(16'($urandom_range(1, 65535)), 1'b0, 255);
        run_random_phase(16'hFFFF, 1'b1, 255);
        run_random_phase(16'($urandom_range(1, 65535)), 1'b1, 255);

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("stepper_trapezoid_ramp_core test passed");
        else
            $display("stepper_trapezoid_ramp_core test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("stepper_trapezoid_ramp_core test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/stramp_pkg.sv
hdl/stramp_if.sv
hdl/stramp_in_stage.sv
hdl/stramp_ramp_state.sv
hdl/stramp_out_stage.sv
hdl/stepper_trapezoid_ramp_core.sv
tb/tb.sv
